@@ rtl/assert_macros.svh @@
// Assertion macros shared by the line discipline RTL.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ttyld_pkg.sv @@
// Shared types, codes and helpers for the tty line discipline.
// No dependencies.
package ttyld_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = CNT_W + 1;

   // request modes
   localparam logic [1:0] MODE_RX    = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   // result kinds
   localparam logic [2:0] K_NONE  = 3'd0;
   localparam logic [2:0] K_ECHO  = 3'd1;
   localparam logic [2:0] K_DATA  = 3'd2;
   localparam logic [2:0] K_EMPTY = 3'd3;
   localparam logic [2:0] K_EOF   = 3'd4;
   localparam logic [2:0] K_FULL  = 3'd5;

   // csr register indexes
   localparam logic [2:0] REG_IFLAG = 3'd0;
   localparam logic [2:0] REG_LFLAG = 3'd1;
   localparam logic [2:0] REG_ERASE = 3'd2;
   localparam logic [2:0] REG_KILL  = 3'd3;
   localparam logic [2:0] REG_EOF   = 3'd4;
   localparam logic [2:0] REG_EOL   = 3'd5;

   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [7:0] CH_NL   = 8'h0a;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] LOW7    = 8'h7f;

   // one accepted beat's worth of results, up to three
   typedef struct packed {
      logic [1:0]      cnt;        // 1..3
      logic [2:0][2:0] kind;
      logic [2:0][7:0] data;
      logic            from_ram;   // data[0] comes from the ring read
      logic            ready_res;
   } item_type;

   function automatic logic ctl_match(input logic [7:0] ch, input logic [7:0] v);
      return (ch != 8'd0) && (ch == v);
   endfunction

endpackage

@@ rtl/ttyld_req_if.sv @@
// Request channel: mode and received byte, valid/ready.
// Uses nothing outside this file.
interface ttyld_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] byte_req;

   modport source (output valid, output mode, output byte_req, input ready);
   modport sink   (input valid, input mode, input byte_req, output ready);
endinterface

@@ rtl/ttyld_rsp_if.sv @@
// Response channel: kind, data, last and ready status, valid/ready.
// Uses nothing outside this file.
interface ttyld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic       last;
   logic       ready_res;

   modport source (output valid, output kind, output data, output last,
                   output ready_res, input ready);
   modport sink   (input valid, input kind, input data, input last,
                   input ready_res, output ready);
endinterface

@@ rtl/tty_canonical_line_discipline.sv @@
// Top level of the terminal input line discipline.
// Depends on ttyld_pkg, ttyld_req_if, ttyld_rsp_if, ttyld_ram, assert_macros.svh.
//
// req channel: one beat per operation. mode 0 hands in a received byte
//   (byte_req), mode 1 reads one committed byte, mode 2 flushes the buffer.
// rsp channel: every request beat yields one to three response beats, the
//   final one flagged by last. ready_res reflects the buffer state after that
//   request (committed bytes or end of file pending).
// csr port: csr_we / csr_index / csr_wdata, write-only, one register per
//   cycle; write only while the block is idle. Unlisted indexes are dropped.
// Timing: a request is decoded and the ring updated in the cycle it is
//   accepted; the decoded request waits in s1 while the ring read port
//   registers its data, then moves into the response register, which drives rsp.
//   Throughput is one request per clock when each causes one response beat
//   and the receiver does not stall; a visual erase holds the response register
//   for three beats. With the receiver stalled, the decode register
//   takes one more request, then req ready stays low until rsp drains.
// Reset: synchronous; clears pointers, counts, eof flag and both stages, and
//   loads the csr defaults. Ring contents are not cleared: only written
//   entries are ever read.
`include "assert_macros.svh"

module tty_canonical_line_discipline (
   input  logic                clock,
   input  logic                reset,
   ttyld_req_if.sink           req_if,
   ttyld_rsp_if.source         rsp_if,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   localparam int ADDR_W   = ttyld_pkg::ADDR_W;
   localparam int CNT_W    = ttyld_pkg::CNT_W;
   localparam int SUM_W    = ttyld_pkg::SUM_W;
   localparam int CAPACITY = ttyld_pkg::CAPACITY;

   // ---------------- configuration registers ----------------
   logic [3:0] iflag_ff;
   logic [4:0] lflag_ff;
   logic [7:0] erase_ff, kill_ff, eofc_ff, eol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iflag_ff <= 4'd1;
         lflag_ff <= 5'd15;
         erase_ff <= 8'd127;
         kill_ff  <= 8'd21;
         eofc_ff  <= 8'd4;
         eol_ff   <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            ttyld_pkg::REG_IFLAG: iflag_ff <= csr_wdata[3:0];
            ttyld_pkg::REG_LFLAG: lflag_ff <= csr_wdata[4:0];
            ttyld_pkg::REG_ERASE: erase_ff <= csr_wdata;
            ttyld_pkg::REG_KILL:  kill_ff  <= csr_wdata;
            ttyld_pkg::REG_EOF:   eofc_ff  <= csr_wdata;
            ttyld_pkg::REG_EOL:   eol_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- buffer state ----------------
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  commit_ff, commit_in;
   logic              eofp_ff, eofp_in;

   // pipeline: s1 holds the decoded request, out drives rsp beats
   ttyld_pkg::item_type s1_ff, item_in, out_ff, out_in;
   logic                s1_vld_ff;
   logic                out_vld_ff;
   logic [1:0]          out_idx_ff;

   logic out_done, out_free, s1_move, req_fire;

   assign out_done = out_vld_ff && rsp_if.ready && (out_idx_ff == 2'(out_ff.cnt - 2'd1));
   assign out_free = !out_vld_ff || out_done;
   assign s1_move  = s1_vld_ff && out_free;
   assign req_if.ready = !s1_vld_ff || s1_move;
   assign req_fire = req_if.valid && req_if.ready;

   // ring
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata, ram_rdata;
   logic [SUM_W-1:0]  wsum;

   ttyld_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   // tail slot = (head + fill) mod CAPACITY; sum stays below twice the depth
   always_comb begin
      wsum = SUM_W'(head_ff) + SUM_W'(fill_ff);
      if (wsum >= SUM_W'(CAPACITY)) begin
         wsum = wsum - SUM_W'(CAPACITY);
      end
   end
   assign ram_waddr = wsum[ADDR_W-1:0];

   // ---------------- request decode ----------------
   logic [7:0] v_map, v;
   logic       canon, echo, is_cr, is_nl;

   always_comb begin
      canon = lflag_ff[0];
      echo  = lflag_ff[1];
      is_cr = (req_if.byte_req == ttyld_pkg::CH_CR);
      is_nl = (req_if.byte_req == ttyld_pkg::CH_NL);

      // input conditioning: CR/NL mapping then bit-7 strip
      if (is_cr) begin
         v_map = iflag_ff[0] ? ttyld_pkg::CH_NL : ttyld_pkg::CH_CR;
      end else if (is_nl && iflag_ff[2]) begin
         v_map = ttyld_pkg::CH_CR;
      end else begin
         v_map = req_if.byte_req;
      end
      v = iflag_ff[3] ? (v_map & ttyld_pkg::LOW7) : v_map;

      head_in   = head_ff;
      fill_in   = fill_ff;
      commit_in = commit_ff;
      eofp_in   = eofp_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_wdata = v;

      item_in.cnt      = 2'd1;
      item_in.kind     = {3{ttyld_pkg::K_NONE}};
      item_in.data     = '0;
      item_in.from_ram = 1'b0;

      unique case (req_if.mode)
         ttyld_pkg::MODE_RX: begin
            if (is_cr && iflag_ff[1]) begin
               // ignored CR: consumed, nothing reported
            end else if (canon && ttyld_pkg::ctl_match(erase_ff, v)) begin
               if (fill_ff > commit_ff) begin
                  fill_in = fill_ff - CNT_W'(1);
                  if (echo && lflag_ff[2]) begin
                     item_in.cnt  = 2'd3;
                     item_in.kind = {3{ttyld_pkg::K_ECHO}};
                     item_in.data = {ttyld_pkg::CH_BS, ttyld_pkg::CH_SP, ttyld_pkg::CH_BS};
                  end else if (echo) begin
                     item_in.kind[0] = ttyld_pkg::K_ECHO;
                     item_in.data[0] = v;
                  end
               end
            end else if (canon && ttyld_pkg::ctl_match(kill_ff, v)) begin
               fill_in = commit_ff;
               if (lflag_ff[3]) begin
                  item_in.kind[0] = ttyld_pkg::K_ECHO;
                  item_in.data[0] = ttyld_pkg::CH_NL;
               end
            end else if (canon && ttyld_pkg::ctl_match(eofc_ff, v)) begin
               if (fill_ff != commit_ff) begin
                  commit_in = fill_ff;
               end else begin
                  eofp_in = 1'b1;
               end
            end else if (fill_ff >= CNT_W'(CAPACITY)) begin
               item_in.kind[0] = ttyld_pkg::K_FULL;
               item_in.data[0] = v;
            end else begin
               ram_we  = req_fire;
               fill_in = fill_ff + CNT_W'(1);
               if (!canon || (v == ttyld_pkg::CH_NL) || ttyld_pkg::ctl_match(eol_ff, v)) begin
                  commit_in = fill_ff + CNT_W'(1);
               end
               if (echo || ((v == ttyld_pkg::CH_NL) && lflag_ff[4])) begin
                  item_in.kind[0] = ttyld_pkg::K_ECHO;
                  item_in.data[0] = v;
               end
            end
         end
         ttyld_pkg::MODE_READ: begin
            if (commit_ff != '0) begin
               ram_re           = req_fire;
               item_in.kind[0]  = ttyld_pkg::K_DATA;
               item_in.from_ram = 1'b1;
               head_in   = (head_ff == ADDR_W'(CAPACITY - 1)) ? '0 : head_ff + ADDR_W'(1);
               fill_in   = fill_ff - CNT_W'(1);
               commit_in = commit_ff - CNT_W'(1);
            end else if (eofp_ff) begin
               eofp_in         = 1'b0;
               item_in.kind[0] = ttyld_pkg::K_EOF;
            end else begin
               item_in.kind[0] = ttyld_pkg::K_EMPTY;
            end
         end
         ttyld_pkg::MODE_FLUSH: begin
            head_in   = '0;
            fill_in   = '0;
            commit_in = '0;
            eofp_in   = 1'b0;
         end
         default: ;
      endcase

      item_in.ready_res = (commit_in != '0) || eofp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         fill_ff   <= '0;
         commit_ff <= '0;
         eofp_ff   <= 1'b0;
      end else if (req_fire) begin
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         commit_ff <= commit_in;
         eofp_ff   <= eofp_in;
      end
   end

   // ---------------- decode stage and response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         out_idx_ff <= 2'd0;
      end else begin
         s1_vld_ff <= req_fire || (s1_vld_ff && !s1_move);
         if (s1_move) begin
            out_vld_ff <= 1'b1;
            out_idx_ff <= 2'd0;
         end else if (out_done) begin
            out_vld_ff <= 1'b0;
         end else if (out_vld_ff && rsp_if.ready) begin
            out_idx_ff <= out_idx_ff + 2'd1;
         end
      end
   end

   // ring read data is valid the cycle after the read, while s1 holds it
   always_comb begin
      out_in = s1_ff;
      if (s1_ff.from_ram) begin
         out_in.data[0] = ram_rdata;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= item_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid     = out_vld_ff;
   assign rsp_if.kind      = out_ff.kind[out_idx_ff];
   assign rsp_if.data      = out_ff.data[out_idx_ff];
   assign rsp_if.last      = (out_idx_ff == 2'(out_ff.cnt - 2'd1));
   assign rsp_if.ready_res = out_ff.ready_res;

   // ---------------- assertions ----------------
   `ASSERT_ALWAYS(a_commit_le_fill, commit_ff <= fill_ff, "commit count above fill count")
   `ASSERT_ALWAYS(a_fill_le_cap, fill_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `ASSERT_ALWAYS(a_beat_idx, !out_vld_ff || (out_idx_ff < out_ff.cnt), "beat index past count")
   `ASSERT_NEXT(a_s1_hold, s1_vld_ff && !s1_move, s1_vld_ff && $stable(s1_ff), "s1 not held")

endmodule

@@ rtl/ttyld_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; contents undefined until written.
module ttyld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
